// ----- rtl/core/fpuvs_pkg.sv -----
// Shared types, codes and saturation helpers for the alpha-chain Verlet stepper.
// Used by the multiplier, the divide-by-three unit and the top level.
package fpuvs_pkg;

  localparam int IDX_W = 6;
  localparam int Q_W = 32;
  localparam int E_W = 48;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_BITS = 8;
  localparam int DIV_STEPS = E_W / DIV_BITS;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic KIND_ENERGY = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NONLINEARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd1;

  typedef struct packed {
    logic signed [Q_W-1:0] a;
    logic signed [Q_W-1:0] b;
    logic                  sh25;
  } mul_req_t;

  function automatic logic signed [63:0] sx64(input logic signed [Q_W-1:0] v);
    return {{32{v[Q_W-1]}}, v};
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/fpu_alpha_chain_verlet_step.sv -----
// Top level: alpha-chain velocity-Verlet stepper with state in on-chip memories.
// Depends on fpuvs_pkg, fpuvs_mul and fpuvs_div3.
//
// channel  direction  handshake               payload
// in_      input      start & !busy           action, particle_index, position, velocity
// out_     output     out_valid, one cycle    total_energy, positions, result_kind
// cfg_     input      cfg_valid & cfg_ready   cfg_index, cfg_data
//
// A load leaves busy low. A read holds busy high for its read state. A step holds
// busy high through the time-step square and the two sweeps over the chain, paced by
// the shared multiplier schedule, and the done state. A result is strobed as busy falls.
// After reset a clearing pass over all PARTICLES+1 entries holds busy high.
// Results are strobed for one cycle and cannot be stalled.
module fpu_alpha_chain_verlet_step #(
  parameter int PARTICLES = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_action,
  input  logic [5:0]             in_particle_index,
  input  logic signed [31:0]     in_load_position,
  input  logic signed [31:0]     in_load_velocity,
  output logic                   out_valid,
  output logic signed [47:0]     out_total_energy,
  output logic signed [31:0]     out_read_position,
  output logic signed [31:0]     out_read_velocity,
  output logic                   out_result_kind,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int DEPTH = PARTICLES + 1;
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(PARTICLES);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DT2, ST_PASS1, ST_PASS2, ST_DONE
  } state_t;

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) begin
      return 48'sh7fffffffffff;
    end else if (v < -64'sd140737488355328) begin
      return 48'sh800000000000;
    end else begin
      return v[47:0];
    end
  endfunction

  state_t state_r;
  logic [4:0] ph_r;
  logic [AW-1:0] j_r;
  logic [AW-1:0] jm1;

  logic signed [31:0] alpha_r;
  logic [30:0] dt_r;
  logic signed [31:0] dt;
  logic signed [31:0] dt2_r;

  logic signed [31:0] x_mem [DEPTH];
  logic signed [31:0] v_mem [DEPTH];
  logic signed [31:0] nx_mem [DEPTH];
  logic signed [31:0] ao_mem [DEPTH];
  logic signed [31:0] x_q, v_q, nx_q, ao_q;
  logic [AW-1:0] x_ra, v_ra, nx_ra, ao_ra;
  logic x_we, v_we, nx_we, ao_we;
  logic [AW-1:0] x_wa, v_wa, nx_wa, ao_wa;
  logic signed [31:0] x_wd, v_wd, nx_wd, ao_wd;

  logic signed [31:0] xprev_r, xcur_r, vprev_r, vcur_r, vi_r, ao_r;
  logic signed [31:0] d_r, sq_r, t1_r, f_r, fprev_r, acc_r, s_r, vn_r;
  logic signed [63:0] e_r;
  logic rd_ok_r;

  logic out_valid_r;
  logic signed [47:0] out_energy_r;
  logic signed [31:0] out_pos_r, out_vel_r;
  logic out_kind_r;

  fpuvs_pkg::mul_req_t mreq;
  logic signed [63:0] mprod;
  logic signed [31:0] mrnd;
  logic div_start;
  logic signed [47:0] div_num, div_quo;
  logic div_done;

  logic [31:0] idx_w;
  logic accept, load_ok, j_ge1, j_ge2, j_inner;
  logic signed [63:0] tmp_cube;

  fpuvs_mul u_mul (.clk(clk), .req(mreq), .prod(mprod), .rnd(mrnd));

  fpuvs_div3 u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .quo(div_quo), .done(div_done)
  );

  assign dt = {1'b0, dt_r};
  assign idx_w = 32'(in_particle_index);
  assign accept = start && !busy;
  assign load_ok = (idx_w >= 32'd1) && (idx_w < 32'(PARTICLES));
  assign jm1 = (j_r == '0) ? '0 : j_r - AW'(1);
  assign j_ge1 = (j_r != '0);
  assign j_ge2 = (j_r >= AW'(2));
  assign j_inner = j_ge1 && (j_r != LAST);
  assign tmp_cube = (mprod + 64'sd98304) >>> 16;
  assign div_num = tmp_cube[47:0];
  assign div_start = (state_r == ST_PASS2) && (ph_r == 5'd11);

  always_comb begin
    x_ra  = AW'(in_particle_index);
    v_ra  = AW'(in_particle_index);
    nx_ra = j_r;
    ao_ra = jm1;
    x_we = 1'b0; v_we = 1'b0; nx_we = 1'b0; ao_we = 1'b0;
    x_wa = j_r; v_wa = jm1; nx_wa = jm1; ao_wa = jm1;
    x_wd = nx_q;
    v_wd = fpuvs_pkg::sat32(fpuvs_pkg::sx64(vi_r) + fpuvs_pkg::sx64(mrnd));
    nx_wd = fpuvs_pkg::sat32(fpuvs_pkg::sx64(xprev_r) + fpuvs_pkg::sx64(t1_r)
                             + fpuvs_pkg::sx64(mrnd));
    ao_wd = acc_r;
    mreq = '0;
    unique case (state_r)
      ST_CLEAR: begin
        x_we = 1'b1; v_we = 1'b1; nx_we = 1'b1;
        v_wa = j_r; nx_wa = j_r;
        x_wd = '0; v_wd = '0; nx_wd = '0;
      end
      ST_IDLE: begin
        if (accept && in_action == fpuvs_pkg::ACT_LOAD && load_ok) begin
          x_we = 1'b1; v_we = 1'b1;
          x_wa = AW'(in_particle_index); v_wa = AW'(in_particle_index);
          x_wd = in_load_position; v_wd = in_load_velocity;
        end
      end
      ST_DT2: begin
        if (ph_r == 5'd0) begin
          mreq.a = dt; mreq.b = dt;
        end
      end
      ST_PASS1: begin
        x_ra = j_r; v_ra = j_r;
        unique case (ph_r)
          5'd2: begin mreq.a = d_r; mreq.b = d_r; end
          5'd3: begin mreq.a = dt; mreq.b = vprev_r; end
          5'd5: begin mreq.a = alpha_r; mreq.b = mrnd; end
          5'd10: begin mreq.a = dt2_r; mreq.b = acc_r; mreq.sh25 = 1'b1; end
          5'd13: begin nx_we = j_ge2; ao_we = j_ge2; end
          default: ;
        endcase
      end
      ST_PASS2: begin
        v_ra = jm1;
        unique case (ph_r)
          5'd1: x_we = j_inner;
          5'd2: begin mreq.a = d_r; mreq.b = d_r; end
          5'd5: begin mreq.a = alpha_r; mreq.b = mrnd; end
          5'd6: begin mreq.a = sq_r; mreq.b = d_r; end
          5'd9: begin mreq.a = alpha_r; mreq.b = mrnd; end
          5'd11: begin mreq.a = dt; mreq.b = s_r; mreq.sh25 = 1'b1; end
          5'd14: v_we = j_ge2;
          5'd15: begin mreq.a = vn_r; mreq.b = vn_r; end
          default: ;
        endcase
      end
      ST_READ, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[x_wa] <= x_wd;
    if (v_we) v_mem[v_wa] <= v_wd;
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (ao_we) ao_mem[ao_wa] <= ao_wd;
    x_q  <= x_mem[x_ra];
    v_q  <= v_mem[v_ra];
    nx_q <= nx_mem[nx_ra];
    ao_q <= ao_mem[ao_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ph_r        <= '0;
      j_r         <= '0;
      alpha_r     <= 32'sd4194304;
      dt_r        <= 31'd1677722;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_READ) || (state_r == ST_DONE);
      if (cfg_valid) begin
        if (cfg_index == fpuvs_pkg::REG_NONLINEARITY) alpha_r <= cfg_data;
        else if (cfg_index == fpuvs_pkg::REG_TIME_STEP) dt_r <= cfg_data[30:0];
      end
      unique case (state_r)
        ST_CLEAR: begin
          j_r <= j_r + AW'(1);
          if (j_r == LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_ok_r <= (idx_w <= 32'(PARTICLES));
            ph_r <= '0;
            j_r  <= '0;
            if (in_action == fpuvs_pkg::ACT_READ) state_r <= ST_READ;
            else if (in_action == fpuvs_pkg::ACT_STEP) state_r <= ST_DT2;
          end
        end
        ST_READ: begin
          out_kind_r   <= fpuvs_pkg::KIND_READ;
          out_energy_r <= '0;
          out_pos_r    <= rd_ok_r ? x_q : '0;
          out_vel_r    <= rd_ok_r ? v_q : '0;
          state_r      <= ST_IDLE;
        end
        ST_DT2: begin
          ph_r <= (ph_r == 5'd3) ? '0 : ph_r + 5'd1;
          if (ph_r == 5'd3) begin
            dt2_r   <= mrnd;
            e_r     <= '0;
            state_r <= ST_PASS1;
          end
        end
        ST_PASS1: begin
          ph_r <= (ph_r == 5'd13) ? '0 : ph_r + 5'd1;
          unique case (ph_r)
            5'd1: begin
              d_r    <= fpuvs_pkg::sat32(fpuvs_pkg::sx64(x_q) - fpuvs_pkg::sx64(xprev_r));
              xcur_r <= x_q;
              vcur_r <= v_q;
            end
            5'd6: t1_r <= mrnd;
            5'd8: f_r <= fpuvs_pkg::sat32(fpuvs_pkg::sx64(d_r) + fpuvs_pkg::sx64(mrnd));
            5'd9: acc_r <= fpuvs_pkg::sat32(fpuvs_pkg::sx64(f_r) - fpuvs_pkg::sx64(fprev_r));
            5'd13: begin
              xprev_r <= xcur_r;
              vprev_r <= vcur_r;
              fprev_r <= f_r;
              if (j_r == LAST) begin
                j_r     <= '0;
                state_r <= ST_PASS2;
              end else begin
                j_r <= j_r + AW'(1);
              end
            end
            default: ;
          endcase
        end
        ST_PASS2: begin
          ph_r <= (ph_r == 5'd18) ? '0 : ph_r + 5'd1;
          unique case (ph_r)
            5'd1: begin
              d_r    <= fpuvs_pkg::sat32(fpuvs_pkg::sx64(nx_q) - fpuvs_pkg::sx64(xprev_r));
              xcur_r <= nx_q;
              vi_r   <= v_q;
              ao_r   <= ao_q;
            end
            5'd4: if (j_ge1) e_r <= e_r + ((mprod + 64'sd65536) >>> 17);
            5'd5: sq_r <= mrnd;
            5'd8: f_r <= fpuvs_pkg::sat32(fpuvs_pkg::sx64(d_r) + fpuvs_pkg::sx64(mrnd));
            5'd9: acc_r <= fpuvs_pkg::sat32(fpuvs_pkg::sx64(f_r) - fpuvs_pkg::sx64(fprev_r));
            5'd10: s_r <= fpuvs_pkg::sat32(fpuvs_pkg::sx64(ao_r) + fpuvs_pkg::sx64(acc_r));
            5'd14: vn_r <= v_wd;
            5'd17: if (j_ge2) e_r <= e_r + ((mprod + 64'sd65536) >>> 17);
            5'd18: begin
              if (j_ge1) e_r <= e_r + {{16{div_quo[47]}}, div_quo};
              xprev_r <= xcur_r;
              fprev_r <= f_r;
              if (j_r == LAST) begin
                state_r <= ST_DONE;
              end else begin
                j_r <= j_r + AW'(1);
              end
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          out_kind_r   <= fpuvs_pkg::KIND_ENERGY;
          out_energy_r <= clamp48(e_r);
          out_pos_r    <= '0;
          out_vel_r    <= '0;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_total_energy = out_energy_r;
  assign out_read_position = out_pos_r;
  assign out_read_velocity = out_vel_r;
  assign out_result_kind = out_kind_r;

`ifndef NO_ASSERTIONS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobed while busy");
  a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS2 && ph_r == 5'd18) |-> div_done)
    else $error("cube quotient not ready");
  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == fpuvs_pkg::ACT_STEP) |=> (state_r == ST_DT2))
    else $error("step item not started");
  a_energy_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == fpuvs_pkg::KIND_ENERGY) |-> $past(state_r == ST_DONE))
    else $error("energy result without finished step");
`endif

endmodule

// ----- rtl/core/fpuvs_mul.sv -----
// Shared pipelined signed multiplier with round-half-up shift and saturation.
// Depends on fpuvs_pkg for the request type and the saturation helper.
module fpuvs_mul (
  input  logic                     clk,
  input  fpuvs_pkg::mul_req_t      req,
  output logic signed [63:0]       prod,
  output logic signed [31:0]       rnd
);

  logic signed [31:0] a_r;
  logic signed [31:0] b_r;
  logic               sh_r;
  logic               sh2_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] rnd_r;

  always_ff @(posedge clk) begin
    a_r    <= req.a;
    b_r    <= req.b;
    sh_r   <= req.sh25;
    prod_r <= a_r * b_r;
    sh2_r  <= sh_r;
    if (sh2_r) begin
      rnd_r <= fpuvs_pkg::sat32((prod_r + 64'sd16777216) >>> 25);
    end else begin
      rnd_r <= fpuvs_pkg::sat32((prod_r + 64'sd8388608) >>> 24);
    end
  end

  assign prod = prod_r;
  assign rnd  = rnd_r;

endmodule

// ----- rtl/core/fpuvs_div3.sv -----
// Iterative floor division of a signed 48-bit value by three, eight bits a cycle.
// Depends on fpuvs_pkg for widths.
module fpuvs_div3 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [fpuvs_pkg::E_W-1:0]    num,
  output logic signed [fpuvs_pkg::E_W-1:0]    quo,
  output logic                                done
);

  localparam int W = fpuvs_pkg::E_W;
  localparam int B = fpuvs_pkg::DIV_BITS;

  logic [W-1:0] m_r;
  logic [W-1:0] q_r;
  logic [1:0]   rem_r;
  logic         neg_r;
  logic         run_r;
  logic [2:0]   cnt_r;
  logic [1:0]   rem_nxt;
  logic [B-1:0] qb_nxt;

  always_comb begin
    logic [2:0] t;
    rem_nxt = rem_r;
    qb_nxt  = '0;
    for (int k = 0; k < B; k++) begin
      t = {rem_nxt, m_r[W-1-k]};
      if (t >= 3'd3) begin
        t = t - 3'd3;
        qb_nxt[B-1-k] = 1'b1;
      end
      rem_nxt = t[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      neg_r <= num[W-1];
      m_r   <= num[W-1] ? (W'(2) - num) : num;
      rem_r <= '0;
      q_r   <= '0;
      run_r <= 1'b1;
      cnt_r <= 3'(fpuvs_pkg::DIV_STEPS);
    end else if (run_r) begin
      m_r   <= m_r << B;
      q_r   <= {q_r[W-B-1:0], qb_nxt};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 3'd1;
      run_r <= (cnt_r != 3'd1);
    end
  end

  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);
  assign done = !run_r;

endmodule

// ----- tb/fpu_alpha_chain_verlet_step_tb.sv -----
// Testbench for the alpha-chain velocity-Verlet stepper: directed and random
// load, step, read and unused-action items checked against an in-bench fixed-point predictor.
// Depends on fpuvs_pkg and fpu_alpha_chain_verlet_step.
module fpu_alpha_chain_verlet_step_tb;

  localparam int NP = 32;
  localparam int STEP_CYC = 5 + 33 * (NP + 1);
  localparam int WDOG_LIMIT = 40 * STEP_CYC;
  localparam longint QMAXV = 64'sd2147483647;
  localparam longint QMINV = -64'sd2147483648;
  localparam longint EMAXV = 64'sd140737488355327;
  localparam longint EMINV = -64'sd140737488355328;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [47:0] energy;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               kind;
  } chain_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = fpuvs_pkg::ACT_LOAD;
  logic [5:0] in_particle_index = '0;
  logic signed [31:0] in_load_position = '0;
  logic signed [31:0] in_load_velocity = '0;
  logic out_valid;
  logic signed [47:0] out_total_energy;
  logic signed [31:0] out_read_position;
  logic signed [31:0] out_read_velocity;
  logic out_result_kind;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = fpuvs_pkg::REG_NONLINEARITY;
  logic [31:0] cfg_data = '0;

  fpu_alpha_chain_verlet_step #(.PARTICLES(NP)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  longint chain_x[NP+1];
  longint chain_v[NP+1];
  longint alpha_q;
  longint dt_q;
  chain_result_t pending_results[$];
  int send_idle_pct;
  int fail_count = 0;
  int quiet_cycles = 0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_q(longint v);
    return clamp64(v, QMINV, QMAXV);
  endfunction

  function automatic longint fix_mul(longint a, longint b, int s);
    return sat_q((a * b + (64'sd1 <<< (s - 1))) >>> s);
  endfunction

  function automatic longint floor_div(longint p, longint d);
    longint q;
    q = p / d;
    if (p % d != 0 && p < 0) q--;
    return q;
  endfunction

  function automatic longint spring(longint d);
    return sat_q(d + fix_mul(alpha_q, fix_mul(d, d, 24), 24));
  endfunction

  function automatic longint net_accel(longint xl, longint xc, longint xr);
    return sat_q(spring(sat_q(xr - xc)) - spring(sat_q(xc - xl)));
  endfunction

  function automatic longint chain_energy();
    longint e;
    longint d;
    longint cube;
    e = 0;
    for (int i = 1; i < NP; i++) e += (chain_v[i] * chain_v[i] + (64'sd1 <<< 16)) >>> 17;
    for (int i = 0; i < NP; i++) begin
      d = sat_q(chain_x[i+1] - chain_x[i]);
      cube = fix_mul(fix_mul(d, d, 24), d, 24);
      e += (d * d + (64'sd1 <<< 16)) >>> 17;
      e += floor_div(alpha_q * cube + 98304, 196608);
    end
    return clamp64(e, EMINV, EMAXV);
  endfunction

  function automatic void verlet_advance();
    longint acc0[NP+1];
    longint xn[NP+1];
    longint dt2;
    longint s;
    dt2 = fix_mul(dt_q, dt_q, 24);
    xn[0] = 0;
    xn[NP] = 0;
    for (int i = 1; i < NP; i++) begin
      acc0[i] = net_accel(chain_x[i-1], chain_x[i], chain_x[i+1]);
      xn[i] = sat_q(chain_x[i] + fix_mul(dt_q, chain_v[i], 24) + fix_mul(dt2, acc0[i], 25));
    end
    for (int i = 1; i < NP; i++) begin
      s = sat_q(acc0[i] + net_accel(xn[i-1], xn[i], xn[i+1]));
      chain_v[i] = sat_q(chain_v[i] + fix_mul(dt_q, s, 25));
    end
    chain_x = xn;
  endfunction

  function automatic void predict_item(logic [1:0] act, logic [5:0] idx,
                                       logic signed [31:0] p, logic signed [31:0] v);
    chain_result_t r;
    r = '0;
    if (act == fpuvs_pkg::ACT_LOAD) begin
      if (idx >= 1 && idx < NP) begin
        chain_x[idx] = longint'(p);
        chain_v[idx] = longint'(v);
      end
    end else if (act == fpuvs_pkg::ACT_STEP) begin
      verlet_advance();
      r.energy = 48'(chain_energy());
      r.kind = fpuvs_pkg::KIND_ENERGY;
      pending_results.push_back(r);
    end else if (act == fpuvs_pkg::ACT_READ) begin
      if (idx <= NP) begin
        r.pos = 32'(chain_x[idx]);
        r.vel = 32'(chain_v[idx]);
      end
      r.kind = fpuvs_pkg::KIND_READ;
      pending_results.push_back(r);
    end
  endfunction

  task automatic send_item(logic [1:0] act, logic [5:0] idx,
                           logic signed [31:0] p, logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_particle_index <= idx;
    in_load_position <= p;
    in_load_velocity <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(act, idx, p, v);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (STEP_CYC + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == fpuvs_pkg::REG_NONLINEARITY) alpha_q = longint'($signed(val));
    else dt_q = longint'(val[30:0]);
  endtask

  function automatic logic signed [31:0] rand_q(int mag_sel);
    case (mag_sel)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    endcase
  endfunction

  task automatic test_directed();
    send_item(fpuvs_pkg::ACT_STEP, 0, 0, 0);
    send_item(fpuvs_pkg::ACT_LOAD, 1, 32'sh7fffffff, 32'sh80000000);
    send_item(fpuvs_pkg::ACT_LOAD, 6'(NP - 1), 32'sh80000000, 32'sh7fffffff);
    send_item(fpuvs_pkg::ACT_LOAD, 0, 32'sh0100_0000, 32'sh0100_0000);
    send_item(fpuvs_pkg::ACT_LOAD, 6'(NP), 32'sh0100_0000, 32'sh0100_0000);
    send_item(fpuvs_pkg::ACT_LOAD, 63, 32'sh0100_0000, 32'sh0100_0000);
    send_item(fpuvs_pkg::ACT_LOAD, 16, 32'sh0100_0000, -32'sh0080_0000);
    send_item(fpuvs_pkg::ACT_LOAD, 42, 32'sh5555_5555, 32'shaaaa_aaaa);
    send_item(ACT_UNUSED, 5, 32'sh1234_5678, 32'sh1234_5678);
    send_item(fpuvs_pkg::ACT_READ, 0, 0, 0);
    send_item(fpuvs_pkg::ACT_READ, 1, 0, 0);
    send_item(fpuvs_pkg::ACT_READ, 6'(NP - 1), 0, 0);
    send_item(fpuvs_pkg::ACT_READ, 6'(NP), 0, 0);
    send_item(fpuvs_pkg::ACT_READ, 63, 0, 0);
    send_item(fpuvs_pkg::ACT_STEP, 0, 0, 0);
    send_item(fpuvs_pkg::ACT_READ, 16, 0, 0);
    send_item(fpuvs_pkg::ACT_STEP, 63, 32'shffff_ffff, 32'shffff_ffff);
    send_item(fpuvs_pkg::ACT_READ, 2, 0, 0);
  endtask

  task automatic test_random(int count);
    int r;
    int mag;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      mag = $urandom_range(9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2);
      if (r < 55)
        send_item(fpuvs_pkg::ACT_LOAD, 6'($urandom_range(63)), rand_q(mag), rand_q(mag));
      else if (r < 63)
        send_item(fpuvs_pkg::ACT_STEP, 6'($urandom_range(63)), $urandom(), $urandom());
      else if (r < 97)
        send_item(fpuvs_pkg::ACT_READ, 6'($urandom_range(63)), $urandom(), $urandom());
      else
        send_item(ACT_UNUSED, 6'($urandom_range(63)), $urandom(), $urandom());
    end
  endtask

  task automatic test_settings();
    logic [31:0] alphas[4];
    logic [31:0] steps[4];
    alphas = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffc0_0000};
    steps = '{32'h7fff_ffff, 32'h0, 32'h0004_0000, 32'h8019_999a};
    for (int k = 0; k < 4; k++) begin
      write_reg(fpuvs_pkg::REG_NONLINEARITY, alphas[k]);
      write_reg(fpuvs_pkg::REG_TIME_STEP, steps[k]);
      test_random(60);
    end
    write_reg(fpuvs_pkg::REG_NONLINEARITY, 32'h0040_0000);
    write_reg(fpuvs_pkg::REG_TIME_STEP, 32'd1677722);
  endtask

  always @(posedge clk) begin
    chain_result_t got;
    chain_result_t want;
    if (rst_n && out_valid) begin
      got = '{out_total_energy, out_read_position, out_read_velocity, out_result_kind};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t kind exp %0d got %0d", $time, want.kind, got.kind);
          fail_count++;
        end
        if (got.energy !== want.energy) begin
          $display("%0t energy exp %0d got %0d", $time, want.energy, got.energy);
          fail_count++;
        end
        if (got.pos !== want.pos) begin
          $display("%0t position exp %0d got %0d", $time, want.pos, got.pos);
          fail_count++;
        end
        if (got.vel !== want.vel) begin
          $display("%0t velocity exp %0d got %0d", $time, want.vel, got.vel);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 35;
    alpha_q = 4194304;
    dt_q = 1677722;
    foreach (chain_x[i]) begin
      chain_x[i] = 0;
      chain_v[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(RANDOM_ITEMS / 2);
    send_idle_pct = 86;
    test_settings();
    send_idle_pct = 0;
    test_random(RANDOM_ITEMS / 2);
    drain();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fpuvs_pkg.sv
rtl/core/fpuvs_mul.sv
rtl/core/fpuvs_div3.sv
rtl/core/fpu_alpha_chain_verlet_step.sv
tb/fpu_alpha_chain_verlet_step_tb.sv
